// File: sv/mqrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue ring manager package
// Operation codes, status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package mqrm_pkg;

  localparam int OP_W     = 3;
  localparam int QID_W    = 4;
  localparam int QSIZE_W  = 7;
  localparam int DATA_W   = 32;
  localparam int OFFSET_W = 6;
  localparam int STATUS_W = 3;
  localparam int NEWQ_W   = 4;
  localparam int OCC_W    = 6;
  localparam int BITCNT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_ENQUEUE = 3'd2,
    OP_DEQUEUE = 3'd3,
    OP_PEEK    = 3'd4,
    OP_GET_AT  = 3'd5,
    OP_COUNT   = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOFREE   = 3'd3,
    ST_NOTALLOC = 3'd4,
    ST_BADSIZE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_ACT,
    S_MOD,
    S_WRAP,
    S_GET,
    S_SLOT
  } state_t;

endpackage

// File: sv/multi_queue_ring_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue ring manager
// Keeps QUEUE_COUNT circular queues of words in one slot memory, with a
// descriptor memory of head, tail and size per queue, under a sequencer.
// ----------------------------------------------------------------------------
// A command word (op, queue_id, queue_size, data_in, offset) is taken at a
// rising edge with start high and busy low. Busy stays high while the
// sequencer works on it. Exactly one result word (status, data_out,
// new_queue, occupancy) follows, shown for one cycle with done high; the
// receiver cannot stall, so it must take it in that cycle.
// The sequencer answers delete, a bad size, an unknown op and an
// unallocated queue from S_EVAL; enqueue, count, and dequeue or peek of an
// empty queue from S_ACT; the other dequeues and peeks go on to S_SLOT, as
// they wait on the slot memory read port. Get at offset reduces the offset
// in S_MOD, one remainder bit per cycle through a shared compare and
// subtract, then answers from S_WRAP when the reduced offset lies past the
// last word, else reads the word through S_GET and S_SLOT. Create scans the
// allocation bits one queue per cycle in S_SCAN. The next command may be
// taken in the cycle that done is high.
// Reset frees every queue. The slot and descriptor memories are not
// cleared: a descriptor is written when its queue is created, and a slot is
// read only after an enqueue has written it.
// ----------------------------------------------------------------------------
module multi_queue_ring_manager #(
  parameter int QUEUE_COUNT = 16,
  parameter int MAX_SLOTS   = 64,
  parameter int WORD_BITS   = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mqrm_pkg::OP_W-1:0]        op,
  input  logic [mqrm_pkg::QID_W-1:0]       queue_id,
  input  logic [mqrm_pkg::QSIZE_W-1:0]     queue_size,
  input  logic [mqrm_pkg::DATA_W-1:0]      data_in,
  input  logic [mqrm_pkg::OFFSET_W-1:0]    offset,
  output logic                             done,
  output logic [mqrm_pkg::STATUS_W-1:0]    status,
  output logic [mqrm_pkg::DATA_W-1:0]      data_out,
  output logic [mqrm_pkg::NEWQ_W-1:0]      new_queue,
  output logic [mqrm_pkg::OCC_W-1:0]       occupancy
);

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int SD = QUEUE_COUNT * MAX_SLOTS;
  localparam int AW = $clog2(SD);

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [SW-1:0] size;
  } desc_t;

  mqrm_pkg::state_t state, state_next;

  logic [QUEUE_COUNT-1:0] alloc;
  desc_t                  desc_mem [QUEUE_COUNT];
  logic [WORD_BITS-1:0]   slot_mem [SD];

  mqrm_pkg::op_t                  op_r;
  logic [QW-1:0]                  q_r;
  logic                           qok_r;
  logic                           valid_r;
  logic [mqrm_pkg::QSIZE_W-1:0]   size_r;
  logic [WORD_BITS-1:0]           word_r;
  logic [mqrm_pkg::OFFSET_W-1:0]  off_r;
  desc_t                          desc_rd;
  logic [WORD_BITS-1:0]           slot_rd;
  logic [AW-1:0]                  base_r, base_next;
  logic [PW-1:0]                  count_r, count_next;
  logic [PW-1:0]                  pos_r, pos_next;
  logic [PW-1:0]                  rem, rem_next;
  logic [mqrm_pkg::BITCNT_W-1:0]  bit_cnt, bit_cnt_next;
  logic [QW-1:0]                  scan, scan_next;

  logic                           accept;
  logic [QW-1:0]                  q_in;
  logic                           q_in_ok;

  logic                           desc_we;
  logic [QW-1:0]                  desc_wa;
  desc_t                          desc_wd;
  logic                           slot_we;
  logic                           slot_re;
  logic [AW-1:0]                  slot_addr;
  logic                           alloc_set;
  logic                           alloc_clr;
  logic [QW-1:0]                  alloc_idx;

  logic                           rsp;
  mqrm_pkg::status_t              rsp_status;
  logic [mqrm_pkg::DATA_W-1:0]    rsp_data;
  logic [mqrm_pkg::NEWQ_W-1:0]    rsp_newq;
  logic [mqrm_pkg::OCC_W-1:0]     rsp_occ;

  logic [PW:0]                    size_ext;
  logic [PW:0]                    cnt_sum;
  logic [PW-1:0]                  count_calc;
  logic [PW:0]                    step_inc;
  logic [PW-1:0]                  pos_calc;
  logic [PW:0]                    trial;
  logic [PW:0]                    wrap_sum;
  logic [PW-1:0]                  wrap_pos;
  logic                           bad_size;

  assign busy      = (state != mqrm_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign q_in      = QW'(queue_id);
  assign q_in_ok   = (32'(queue_id) < QUEUE_COUNT);
  assign slot_addr = base_r + AW'(pos_r);

  assign size_ext   = (PW+1)'(desc_rd.size);
  assign cnt_sum    = (PW+1)'(desc_rd.tail) + size_ext - (PW+1)'(desc_rd.head);
  assign count_calc = (desc_rd.tail >= desc_rd.head) ? PW'(desc_rd.tail - desc_rd.head)
                                                     : PW'(cnt_sum);
  assign step_inc   = (op_r == mqrm_pkg::OP_ENQUEUE) ? (PW+1)'(desc_rd.tail) + 1'b1
                                                     : (PW+1)'(desc_rd.head) + 1'b1;
  assign pos_calc   = (step_inc >= size_ext) ? '0 : PW'(step_inc);
  assign trial      = {rem, off_r[bit_cnt]};
  assign wrap_sum   = (PW+1)'(desc_rd.head) + (PW+1)'(rem) + 1'b1;
  assign wrap_pos   = (wrap_sum >= size_ext) ? PW'(wrap_sum - size_ext) : PW'(wrap_sum);
  assign bad_size   = (size_r == '0) || (32'(size_r) > MAX_SLOTS);

  always_comb begin
    state_next = state;
    unique case (state)
      mqrm_pkg::S_IDLE: begin
        if (start) state_next = mqrm_pkg::S_EVAL;
      end
      mqrm_pkg::S_EVAL: begin
        unique case (op_r)
          mqrm_pkg::OP_CREATE: begin
            state_next = bad_size ? mqrm_pkg::S_IDLE : mqrm_pkg::S_SCAN;
          end
          mqrm_pkg::OP_ENQUEUE, mqrm_pkg::OP_DEQUEUE, mqrm_pkg::OP_PEEK,
          mqrm_pkg::OP_GET_AT, mqrm_pkg::OP_COUNT: begin
            state_next = valid_r ? mqrm_pkg::S_ACT : mqrm_pkg::S_IDLE;
          end
          default: state_next = mqrm_pkg::S_IDLE;
        endcase
      end
      mqrm_pkg::S_SCAN: begin
        if (!alloc[scan] || (scan == QW'(QUEUE_COUNT - 1))) state_next = mqrm_pkg::S_IDLE;
      end
      mqrm_pkg::S_ACT: begin
        unique case (op_r)
          mqrm_pkg::OP_DEQUEUE, mqrm_pkg::OP_PEEK: begin
            state_next = (desc_rd.head == desc_rd.tail) ? mqrm_pkg::S_IDLE
                                                        : mqrm_pkg::S_SLOT;
          end
          mqrm_pkg::OP_GET_AT: state_next = mqrm_pkg::S_MOD;
          default:             state_next = mqrm_pkg::S_IDLE;
        endcase
      end
      mqrm_pkg::S_MOD: begin
        if (bit_cnt == '0) state_next = mqrm_pkg::S_WRAP;
      end
      mqrm_pkg::S_WRAP: begin
        state_next = (rem >= count_r) ? mqrm_pkg::S_IDLE : mqrm_pkg::S_GET;
      end
      mqrm_pkg::S_GET:  state_next = mqrm_pkg::S_SLOT;
      mqrm_pkg::S_SLOT: state_next = mqrm_pkg::S_IDLE;
      default:          state_next = mqrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    base_next    = base_r;
    count_next   = count_r;
    pos_next     = pos_r;
    rem_next     = rem;
    bit_cnt_next = bit_cnt;
    scan_next    = scan;
    desc_we      = 1'b0;
    desc_wa      = q_r;
    desc_wd      = desc_rd;
    slot_we      = 1'b0;
    slot_re      = 1'b0;
    alloc_set    = 1'b0;
    alloc_clr    = 1'b0;
    alloc_idx    = q_r;
    rsp          = 1'b0;
    rsp_status   = mqrm_pkg::ST_OK;
    rsp_data     = '0;
    rsp_newq     = '0;
    rsp_occ      = '0;
    unique case (state)
      mqrm_pkg::S_IDLE: begin
      end
      mqrm_pkg::S_EVAL: begin
        base_next  = AW'(AW'(q_r) * MAX_SLOTS);
        count_next = count_calc;
        pos_next   = pos_calc;
        scan_next  = '0;
        unique case (op_r)
          mqrm_pkg::OP_CREATE: begin
            if (bad_size) begin
              rsp        = 1'b1;
              rsp_status = mqrm_pkg::ST_BADSIZE;
            end
          end
          mqrm_pkg::OP_DELETE: begin
            rsp = 1'b1;
            if (qok_r) begin
              alloc_clr = 1'b1;
              desc_we   = 1'b1;
              desc_wd   = '0;
            end else begin
              rsp_status = mqrm_pkg::ST_NOTALLOC;
            end
          end
          mqrm_pkg::OP_ENQUEUE, mqrm_pkg::OP_DEQUEUE, mqrm_pkg::OP_PEEK,
          mqrm_pkg::OP_GET_AT, mqrm_pkg::OP_COUNT: begin
            if (!valid_r) begin
              rsp        = 1'b1;
              rsp_status = mqrm_pkg::ST_NOTALLOC;
            end
          end
          default: rsp = 1'b1;
        endcase
      end
      mqrm_pkg::S_SCAN: begin
        scan_next = scan + 1'b1;
        alloc_idx = scan;
        if (!alloc[scan]) begin
          alloc_set    = 1'b1;
          desc_we      = 1'b1;
          desc_wa      = scan;
          desc_wd      = '0;
          desc_wd.size = SW'(size_r);
          rsp          = 1'b1;
          rsp_newq     = mqrm_pkg::NEWQ_W'(scan);
        end else if (scan == QW'(QUEUE_COUNT - 1)) begin
          rsp        = 1'b1;
          rsp_status = mqrm_pkg::ST_NOFREE;
        end
      end
      mqrm_pkg::S_ACT: begin
        rem_next     = '0;
        bit_cnt_next = mqrm_pkg::BITCNT_W'(mqrm_pkg::OFFSET_W - 1);
        rsp_occ      = mqrm_pkg::OCC_W'(count_r);
        unique case (op_r)
          mqrm_pkg::OP_ENQUEUE: begin
            rsp = 1'b1;
            if (pos_r == desc_rd.head) begin
              rsp_status = mqrm_pkg::ST_FULL;
            end else begin
              slot_we      = 1'b1;
              desc_we      = 1'b1;
              desc_wd.tail = pos_r;
              rsp_occ      = mqrm_pkg::OCC_W'(count_r + 1'b1);
            end
          end
          mqrm_pkg::OP_DEQUEUE, mqrm_pkg::OP_PEEK: begin
            if (desc_rd.head == desc_rd.tail) begin
              rsp        = 1'b1;
              rsp_status = mqrm_pkg::ST_EMPTY;
            end else begin
              slot_re    = 1'b1;
              count_next = (op_r == mqrm_pkg::OP_DEQUEUE) ? count_r - 1'b1 : count_r;
              if (op_r == mqrm_pkg::OP_DEQUEUE) begin
                desc_we      = 1'b1;
                desc_wd.head = pos_r;
              end
            end
          end
          mqrm_pkg::OP_GET_AT: begin
          end
          default: rsp = 1'b1;
        endcase
      end
      mqrm_pkg::S_MOD: begin
        bit_cnt_next = bit_cnt - 1'b1;
        rem_next     = (trial >= size_ext) ? PW'(trial - size_ext) : PW'(trial);
      end
      mqrm_pkg::S_WRAP: begin
        pos_next = wrap_pos;
        if (rem >= count_r) begin
          rsp     = 1'b1;
          rsp_occ = mqrm_pkg::OCC_W'(count_r);
        end
      end
      mqrm_pkg::S_GET: begin
        slot_re = 1'b1;
      end
      mqrm_pkg::S_SLOT: begin
        rsp      = 1'b1;
        rsp_data = mqrm_pkg::DATA_W'(slot_rd);
        rsp_occ  = mqrm_pkg::OCC_W'(count_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqrm_pkg::S_IDLE;
      done  <= 1'b0;
      alloc <= '0;
    end else begin
      state <= state_next;
      done  <= rsp;
      if (alloc_set) alloc[alloc_idx] <= 1'b1;
      if (alloc_clr) alloc[alloc_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= mqrm_pkg::op_t'(op);
      q_r     <= q_in;
      qok_r   <= q_in_ok;
      valid_r <= q_in_ok && alloc[q_in];
      size_r  <= queue_size;
      word_r  <= WORD_BITS'(data_in);
      off_r   <= offset;
    end
    base_r  <= base_next;
    count_r <= count_next;
    pos_r   <= pos_next;
    rem     <= rem_next;
    bit_cnt <= bit_cnt_next;
    scan    <= scan_next;
    if (rsp) begin
      status    <= rsp_status;
      data_out  <= rsp_data;
      new_queue <= rsp_newq;
      occupancy <= rsp_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) desc_mem[desc_wa] <= desc_wd;
    if (accept) desc_rd <= desc_mem[q_in];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_addr] <= word_r;
    if (slot_re) slot_rd <= slot_mem[slot_addr];
  end

endmodule
